// ----- hw/rtl/mrdm_pkg.sv -----
// Package for the median residual defect map block.
// Holds the register map, configuration constants and the cell control struct.
// No dependencies.
`default_nettype none
package mrdm_pkg;

    localparam int APB_ADDR_BITS = 3;
    localparam int REG_BITS      = 11;
    localparam int ROW_BITS      = 10;
    localparam int MAX_HEIGHT    = 1024;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic valid;
        logic last;
    } cell_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mrdm_stream_if.sv -----
// Stream interfaces for the pixel request channel and the result channel.
// Depends on nothing; widths follow the pixel width parameter.
`default_nettype none
interface mrdm_pixel_if #(parameter int PIXEL_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface mrdm_result_if #(parameter int PIXEL_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic [PIXEL_BITS-1:0]        center_value;
    logic [PIXEL_BITS-1:0]        median_value;
    logic signed [PIXEL_BITS:0]   residual;
    logic                         frame_last;

    modport source (output valid, output center_value, output median_value,
                    output residual, output frame_last, input ready);
    modport sink   (input valid, input center_value, input median_value,
                    input residual, input frame_last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/mrdm_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module mrdm_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/mrdm_cell.sv -----
// One cell of the median chain: settles one bit of the median, MSB first.
// Depends on mrdm_pkg for the control struct.
`default_nettype none
module mrdm_cell #(
    parameter int AREA       = 49,
    parameter int PIXEL_BITS = 16,
    parameter int BIT_INDEX  = 15
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             advance,
    input  wire mrdm_pkg::cell_ctl_t              in_ctl,
    input  wire logic [AREA*PIXEL_BITS-1:0]       in_values,
    input  wire logic [AREA-1:0]                  in_alive,
    input  wire logic [$clog2(AREA+1)-1:0]        in_rank,
    input  wire logic [PIXEL_BITS-1:0]            in_median,
    input  wire logic [PIXEL_BITS-1:0]            in_center,
    output mrdm_pkg::cell_ctl_t                   out_ctl,
    output logic      [AREA*PIXEL_BITS-1:0]       out_values,
    output logic      [AREA-1:0]                  out_alive,
    output logic      [$clog2(AREA+1)-1:0]        out_rank,
    output logic      [PIXEL_BITS-1:0]            out_median,
    output logic      [PIXEL_BITS-1:0]            out_center
);
    import mrdm_pkg::*;

    localparam int CNT_BITS = $clog2(AREA+1);

    logic [AREA-1:0]           bit_vec;
    logic [AREA-1:0]           zeros;
    logic [CNT_BITS-1:0]       zero_count;
    logic                      take_zero;
    cell_ctl_t                 ctl_reg;
    logic [AREA*PIXEL_BITS-1:0] values_reg;
    logic [AREA-1:0]           alive_reg;
    logic [CNT_BITS-1:0]       rank_reg;
    logic [PIXEL_BITS-1:0]     median_reg;
    logic [PIXEL_BITS-1:0]     center_reg;
    logic [PIXEL_BITS-1:0]     median_next;

    always_comb
    begin
        zero_count = '0;
        for (int j = 0; j < AREA; j++)
        begin
            bit_vec[j] = in_values[j*PIXEL_BITS + BIT_INDEX];
            zeros[j]   = in_alive[j] & ~bit_vec[j];
            zero_count = zero_count + CNT_BITS'(zeros[j]);
        end
        take_zero = in_rank < zero_count;
        median_next = in_median;
        median_next[BIT_INDEX] = ~take_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            values_reg <= in_values;
            median_reg <= median_next;
            center_reg <= in_center;
            if (take_zero)
            begin
                alive_reg <= zeros;
                rank_reg  <= in_rank;
            end
            else
            begin
                alive_reg <= in_alive & bit_vec;
                rank_reg  <= in_rank - zero_count;
            end
        end
    end

    assign out_ctl    = ctl_reg;
    assign out_values = values_reg;
    assign out_alive  = alive_reg;
    assign out_rank   = rank_reg;
    assign out_median = median_reg;
    assign out_center = center_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/median_residual_defect_map.sv -----
// Top level of the median residual defect map: line store, window and median chain.
// Depends on mrdm_pkg, mrdm_stream_if, mrdm_ram and mrdm_cell.
//
// Pixels enter in raster order at one request per clock when the result side does not
// stall. Each interior pixel, at least WINDOW/2 from every edge, yields its value, the
// median of its WINDOW x WINDOW neighborhood and the signed residual; the result for
// pixel (r-3, c-3) follows the request for pixel (r, c). Between request and result lie
// the line store read, the window shift, one chain cell per pixel bit and the output
// register. A held result stalls the whole pipeline.
// Width and height are written over APB at byte addresses 0 and 4 and are clamped
// into their valid ranges.
`default_nettype none
module median_residual_defect_map #(
    parameter int WINDOW     = 7,
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    mrdm_pixel_if.sink                               pixel_in,
    mrdm_result_if.source                            result_out,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mrdm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready
);
    import mrdm_pkg::*;

    localparam int HALF      = WINDOW / 2;
    localparam int AREA      = WINDOW * WINDOW;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int WID_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int LINE_BITS = (WINDOW - 1) * PIXEL_BITS;
    localparam int RANK_BITS = $clog2(AREA + 1);
    localparam int WID_RST   = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic [WID_BITS-1:0]   width_reg;
    logic [REG_BITS-1:0]   height_reg;
    logic [31:0]           wr_value;
    logic                  cfg_write;

    logic                  advance;
    logic                  accept;
    logic [COL_BITS-1:0]   col_reg;
    logic [ROW_BITS-1:0]   row_reg;
    logic                  row_end;
    logic                  frame_end;
    logic                  produce;

    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic [COL_BITS-1:0]   s1_addr_reg;
    logic                  s1_produce_reg;
    logic                  s1_last_reg;
    logic [LINE_BITS-1:0]  line_rd;
    logic [LINE_BITS-1:0]  line_wr;
    logic [PIXEL_BITS-1:0] col_vals [WINDOW];

    logic [PIXEL_BITS-1:0] win_reg [WINDOW][WINDOW];
    logic [AREA*PIXEL_BITS-1:0] win_flat;
    cell_ctl_t             s2_ctl_reg;

    cell_ctl_t                  chain_ctl    [PIXEL_BITS+1];
    logic [AREA*PIXEL_BITS-1:0] chain_values [PIXEL_BITS];
    logic [AREA-1:0]            chain_alive  [PIXEL_BITS];
    logic [RANK_BITS-1:0]       chain_rank   [PIXEL_BITS];
    logic [PIXEL_BITS-1:0]      chain_median [PIXEL_BITS+1];
    logic [PIXEL_BITS-1:0]      chain_center [PIXEL_BITS+1];

    logic                  out_valid_reg;
    logic [PIXEL_BITS-1:0] out_center_reg;
    logic [PIXEL_BITS-1:0] out_median_reg;
    logic [PIXEL_BITS:0]   out_residual_reg;
    logic                  out_last_reg;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign wr_value  = {21'd0, pwdata[REG_BITS-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WID_BITS'(WID_RST);
            height_reg <= REG_BITS'(HEIGHT_RESET);
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(paddr[2]))
                REG_IMAGE_WIDTH:
                begin
                    if (wr_value < 32'(WINDOW))
                    begin
                        width_reg <= WID_BITS'(WINDOW);
                    end
                    else if (wr_value > 32'(MAX_WIDTH))
                    begin
                        width_reg <= WID_BITS'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_reg <= WID_BITS'(wr_value);
                    end
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (wr_value < 32'(WINDOW))
                    begin
                        height_reg <= REG_BITS'(WINDOW);
                    end
                    else if (wr_value > 32'(MAX_HEIGHT))
                    begin
                        height_reg <= REG_BITS'(MAX_HEIGHT);
                    end
                    else
                    begin
                        height_reg <= REG_BITS'(wr_value);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index_t'(paddr[2]))
            REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // Position counters and request acceptance.
    assign advance        = !out_valid_reg || result_out.ready;
    assign pixel_in.ready = advance;
    assign accept         = pixel_in.valid && advance;
    assign row_end        = (WID_BITS'(col_reg) + WID_BITS'(1)) >= width_reg;
    assign frame_end      = row_end && ((REG_BITS'(row_reg) + REG_BITS'(1)) >= height_reg);
    assign produce        = (32'(col_reg) >= 32'(WINDOW - 1))
                            && (32'(row_reg) >= 32'(WINDOW - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pixel_in.valid;
            if (pixel_in.valid)
            begin
                if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= frame_end ? '0 : row_reg + ROW_BITS'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg   <= pixel_in.pixel_value;
            s1_addr_reg    <= col_reg;
            s1_produce_reg <= produce;
            s1_last_reg    <= frame_end;
        end
    end

    // Line store: one word per column holds the previous WINDOW-1 rows.
    mrdm_ram #(
        .WIDTH (LINE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (advance && s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (line_wr),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (line_rd)
    );

    assign line_wr = {s1_pixel_reg, line_rd[LINE_BITS-1:PIXEL_BITS]};

    always_comb
    begin
        for (int k = 0; k < WINDOW - 1; k++)
        begin
            col_vals[k] = line_rd[k*PIXEL_BITS +: PIXEL_BITS];
        end
        col_vals[WINDOW-1] = s1_pixel_reg;
    end

    // Window registers shift one column per pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctl_reg <= '0;
            for (int k = 0; k < WINDOW; k++)
            begin
                for (int j = 0; j < WINDOW; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
        end
        else if (advance)
        begin
            s2_ctl_reg.valid <= s1_valid_reg && s1_produce_reg;
            s2_ctl_reg.last  <= s1_last_reg;
            if (s1_valid_reg)
            begin
                for (int k = 0; k < WINDOW; k++)
                begin
                    for (int j = 0; j < WINDOW - 1; j++)
                    begin
                        win_reg[k][j] <= win_reg[k][j+1];
                    end
                    win_reg[k][WINDOW-1] <= col_vals[k];
                end
            end
        end
    end

    // Median chain: one cell per pixel bit.
    always_comb
    begin
        for (int k = 0; k < WINDOW; k++)
        begin
            for (int j = 0; j < WINDOW; j++)
            begin
                win_flat[(k*WINDOW + j)*PIXEL_BITS +: PIXEL_BITS] = win_reg[k][j];
            end
        end
    end

    assign chain_values[0] = win_flat;
    assign chain_ctl[0]    = s2_ctl_reg;
    assign chain_alive[0]  = '1;
    assign chain_rank[0]   = RANK_BITS'(AREA / 2);
    assign chain_median[0] = '0;
    assign chain_center[0] = win_reg[HALF][HALF];

    for (genvar c = 0; c < PIXEL_BITS; c++)
    begin : g_cell
        if (c < PIXEL_BITS - 1)
        begin : g_mid
            mrdm_cell #(
                .AREA       (AREA),
                .PIXEL_BITS (PIXEL_BITS),
                .BIT_INDEX  (PIXEL_BITS - 1 - c)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .advance    (advance),
                .in_ctl     (chain_ctl[c]),
                .in_values  (chain_values[c]),
                .in_alive   (chain_alive[c]),
                .in_rank    (chain_rank[c]),
                .in_median  (chain_median[c]),
                .in_center  (chain_center[c]),
                .out_ctl    (chain_ctl[c+1]),
                .out_values (chain_values[c+1]),
                .out_alive  (chain_alive[c+1]),
                .out_rank   (chain_rank[c+1]),
                .out_median (chain_median[c+1]),
                .out_center (chain_center[c+1])
            );
        end
        else
        begin : g_last
            mrdm_cell #(
                .AREA       (AREA),
                .PIXEL_BITS (PIXEL_BITS),
                .BIT_INDEX  (PIXEL_BITS - 1 - c)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .advance    (advance),
                .in_ctl     (chain_ctl[c]),
                .in_values  (chain_values[c]),
                .in_alive   (chain_alive[c]),
                .in_rank    (chain_rank[c]),
                .in_median  (chain_median[c]),
                .in_center  (chain_center[c]),
                .out_ctl    (chain_ctl[c+1]),
                .out_values (),
                .out_alive  (),
                .out_rank   (),
                .out_median (chain_median[c+1]),
                .out_center (chain_center[c+1])
            );
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_ctl[PIXEL_BITS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_center_reg   <= chain_center[PIXEL_BITS];
            out_median_reg   <= chain_median[PIXEL_BITS];
            out_residual_reg <= {1'b0, chain_center[PIXEL_BITS]}
                                - {1'b0, chain_median[PIXEL_BITS]};
            out_last_reg     <= chain_ctl[PIXEL_BITS].last;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.center_value = out_center_reg;
    assign result_out.median_value = out_median_reg;
    assign result_out.residual     = out_residual_reg;
    assign result_out.frame_last   = out_last_reg;
endmodule
`default_nettype wire

// ----- bench/median_residual_defect_map_tb.sv -----
// Self-checking testbench for the median residual defect map block.
// Depends on mrdm_pkg, the stream interfaces in mrdm_stream_if and the block itself.
// A behavioral window model predicts each interior result and checks it in order.
`default_nettype none
module median_residual_defect_map_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mrdm_pkg::*;

    localparam int WIN    = 7;
    localparam int MAXW   = 1024;
    localparam int PBITS  = 16;
    localparam int LAT    = PBITS + 8;
    localparam int LIMIT  = 2000000;

    typedef struct packed {
        logic [15:0]        center;
        logic [15:0]        median;
        logic signed [16:0] resid;
        logic               last;
    } defect_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;

    mrdm_pixel_if  #(.PIXEL_BITS(PBITS)) pix_ch ();
    mrdm_result_if #(.PIXEL_BITS(PBITS)) res_ch ();

    median_residual_defect_map #(.WINDOW(WIN), .MAX_WIDTH(MAXW), .PIXEL_BITS(PBITS)) dut (
        .clk(clk), .rst_n(rst_n), .pixel_in(pix_ch.sink), .result_out(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [15:0] line_mem [WIN-1][MAXW];
    logic [15:0] win_regs [WIN][WIN];
    int unsigned col_pos, row_pos, width_used, height_used;
    defect_t expected_q [$];
    int errors;
    int cycles;
    int stall_hold;
    int long_hold;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("median_residual_defect_map regression: fail");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic int unsigned clamp_size(input logic [31:0] v);
        int unsigned x;
        x = v[10:0];
        if (x < WIN) return WIN;
        if (x > MAXW) return MAXW;
        return x;
    endfunction

    function automatic logic [15:0] window_median();
        logic [15:0] vals [$];
        for (int i = 0; i < WIN; i++)
            for (int j = 0; j < WIN; j++)
                vals = {vals, win_regs[i][j]};
        vals.sort();
        return vals[(WIN * WIN) / 2];
    endfunction

    task automatic predict_pixel(input logic [15:0] pix);
        logic [15:0] colv [WIN];
        logic row_end, frame_end;
        logic [15:0] med, ctr;
        defect_t d;
        row_end = (col_pos + 1 >= width_used);
        frame_end = row_end && (row_pos + 1 >= height_used);
        for (int k = 0; k < WIN - 1; k++)
            colv[k] = line_mem[k][col_pos % MAXW];
        colv[WIN-1] = pix;
        for (int k = 0; k < WIN - 1; k++)
            line_mem[k][col_pos % MAXW] = colv[k+1];
        for (int k = 0; k < WIN; k++)
        begin
            for (int j = 0; j < WIN - 1; j++)
                win_regs[k][j] = win_regs[k][j+1];
            win_regs[k][WIN-1] = colv[k];
        end
        if (col_pos >= WIN - 1 && row_pos >= WIN - 1)
        begin
            ctr = win_regs[WIN/2][WIN/2];
            med = window_median();
            d.center = ctr;
            d.median = med;
            d.resid = $signed({1'b0, ctr}) - $signed({1'b0, med});
            d.last = frame_end;
            expected_q = {expected_q, d};
        end
        if (row_end)
        begin
            col_pos = 0;
            row_pos = frame_end ? 0 : (row_pos + 1) & 10'h3FF;
        end
        else
            col_pos = (col_pos + 1) & 10'h3FF;
    endtask

    // Results are sampled at the edge; ready changes with nonblocking assignments.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_q.size() == 0)
                report("unexpected result", 1, 0);
            else
            begin
                defect_t e;
                e = expected_q.pop_front();
                if (res_ch.center_value !== e.center)
                    report("center_value", res_ch.center_value, e.center);
                if (res_ch.median_value !== e.median)
                    report("median_value", res_ch.median_value, e.median);
                if (res_ch.residual !== e.resid)
                    report("residual", res_ch.residual, e.resid);
                if (res_ch.frame_last !== e.last)
                    report("frame_last", res_ch.frame_last, e.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (long_hold > 0)
        begin
            res_ch.ready <= 1'b0;
            long_hold <= long_hold - 1;
        end
        else if (stall_hold > 0)
        begin
            res_ch.ready <= ($urandom_range(0, 3) != 0);
            stall_hold <= stall_hold - 1;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            if ($urandom_range(0, 40) == 0)
                stall_hold <= $urandom_range(5, 60);
        end
    end

    task automatic send_pixel(input logic [15:0] pix);
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_value <= pix;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        predict_pixel(pix);
    endtask

    task automatic idle_sender(input int n);
        pix_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        idle_sender(1);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LAT * 2) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_BITS'(int'(idx) * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_used = clamp_size(value);
        else
            height_used = clamp_size(value);
        @(posedge clk);
    endtask

    task automatic set_size(input logic [31:0] w, input logic [31:0] h);
        drain();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(16'h7F00, 16'h8100));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frames(input int n, input bit bursty);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (bursty && burst == 0)
            begin
                if ($urandom_range(0, 2) == 0)
                    idle_sender($urandom_range(1, 12));
                burst = $urandom_range(1, 40);
            end
            send_pixel(rand_pixel());
            if (burst > 0)
                burst--;
        end
    endtask

    task automatic test_extremes();
        set_size(7, 7);
        for (int i = 0; i < 49; i++)
            send_pixel((i % 2) ? 16'hFFFF : 16'h0000);
        drain();
        for (int i = 0; i < 49; i++)
            send_pixel((i == 24) ? 16'hFFFF : 16'h0000);
        for (int i = 0; i < 49; i++)
            send_pixel((i == 24) ? 16'h0000 : 16'hFFFF);
    endtask

    task automatic test_clamped_sizes();
        set_size(32'h0000_0000, 32'hFFFF_FFFF);
        set_size(32'h0000_07FF, 32'h0000_0003);
        set_size(8, 9);
        send_frames(72, 1'b0);
    endtask

    task automatic test_mid_image_resize();
        set_size(12, 10);
        send_frames(70, 1'b1);
        set_size(8, 8);
        send_frames(17 + 20, 1'b1);
    endtask

    task automatic test_random_frames();
        for (int f = 0; f < 2; f++)
        begin
            set_size($urandom_range(7, 12), $urandom_range(7, 10));
            send_frames(width_used * height_used, 1'b1);
        end
    endtask

    task automatic test_backpressure();
        set_size(9, 9);
        send_frames(30, 1'b0);
        long_hold <= 200;
        send_frames(60, 1'b0);
        drain();
        send_frames(2 * 81 - 90, 1'b0);
    endtask

    task automatic test_tall_frame();
        set_size(7, 1024);
        send_frames(7 * 10, 1'b1);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        stall_hold = 0;
        long_hold = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel_value = '0;
        res_ch.ready = 1'b1;
        col_pos = 0;
        row_pos = 0;
        width_used = WIDTH_RESET;
        height_used = HEIGHT_RESET;
        for (int k = 0; k < WIN - 1; k++)
            for (int c = 0; c < MAXW; c++)
                line_mem[k][c] = '0;
        for (int i = 0; i < WIN; i++)
            for (int j = 0; j < WIN; j++)
                win_regs[i][j] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_clamped_sizes();
        test_mid_image_resize();
        test_random_frames();
        test_backpressure();
        test_tall_frame();
        drain();
        if (errors == 0)
            $display("median_residual_defect_map regression: pass");
        else
            $display("median_residual_defect_map regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
